// ===== rtl/fpa_pkg.sv =====
// shared types, opcodes and constants for the q24.8 fixed-point alu
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    // quotient bits produced by the divider chain
    localparam int QUO_W     = WORD_W + FRAC_BITS + 1;
    localparam int NUM_W     = QUO_W;
    localparam int DEN_W     = WORD_W + 2;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } op_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               compare_true;
        logic [1:0]         status;
    } out_word_t;

    // result of the simple operations, carried beside the divider
    typedef struct packed {
        logic               is_div;
        logic               is_mul;
        logic               neg;
        logic               div0;
        logic signed [31:0] value;
        logic               compare_true;
        logic [1:0]         status;
        logic signed [63:0] product;
    } side_t;

    // one divider cell's state: shifted dividend, divisor, partial remainder, quotient and side result
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        side_t            side;
    } div_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic ovf);
        logic signed [31:0] r;
        begin
            ovf = 1'b0;
            r   = v[31:0];
            if (v > 66'sh0_7FFF_FFFF)
            begin
                ovf = 1'b1;
                r   = 32'sh7FFF_FFFF;
            end
            else if (v < -66'sh0_8000_0000)
            begin
                ovf = 1'b1;
                r   = -32'sh8000_0000;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/fixed_point_alu_q24_8_core.sv =====
// top level of the q24.8 fixed-point alu
// usage:
//   in channel: in_valid/in_stall with in_word (kind, operand_a, operand_b);
//   out channel: out_valid/out_stall with out_word (value, compare_true, status).
//   every operation travels the same pipe: a decode stage, a chain of
//   QUO_W divider cells (one quotient bit each, 41 at eight fraction bits),
//   and a rounding stage. throughput is one word per cycle while the
//   pipe does not hold; the cell chain sets the latency.
//   when the receiver stalls with a word waiting at the output, the whole
//   pipe holds; in_stall then follows out_stall. while the output
//   register is empty the pipe advances regardless, so an empty output never holds it.
//   reset clears all valid bits; no words are in flight afterwards.
//   results come out in the order words were taken.
module fixed_point_alu_q24_8_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fpa_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output fpa_pkg::out_word_t out_word
);

    localparam int N = fpa_pkg::QUO_W;

    logic en;
    logic v_front;
    fpa_pkg::div_state_t st_front;
    logic                v_c [N+1];
    fpa_pkg::div_state_t st_c [N+1];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    fpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_word  (in_word),
        .v_reg    (v_front),
        .st_reg   (st_front)
    );

    // front valid is already gated with the input handshake
    logic fv;
    assign fv = v_front;

    assign v_c[0]  = fv;
    assign st_c[0] = st_front;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fpa_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .v_in   (v_c[i]),
            .st_in  (st_c[i]),
            .v_reg  (v_c[i+1]),
            .st_reg (st_c[i+1])
        );
    end

    fpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .v_in    (v_c[N]),
        .st_in   (st_c[N]),
        .v_reg   (out_valid),
        .out_reg (out_word)
    );

endmodule

// ===== rtl/fpa_front.sv =====
// front stage: decodes the opcode and computes the simple operations
module fpa_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  fpa_pkg::in_word_t  in_word,
    output logic               v_reg,
    output fpa_pkg::div_state_t st_reg
);

    fpa_pkg::div_state_t st_next;
    logic signed [65:0] a, b, wide;
    logic ovf;
    logic [31:0] mag_a, mag_b;

    always_comb
    begin
        a = 66'(in_word.operand_a);
        b = 66'(in_word.operand_b);
        mag_a = in_word.operand_a[31] ? 32'(-in_word.operand_a) : in_word.operand_a;
        mag_b = in_word.operand_b[31] ? 32'(-in_word.operand_b) : in_word.operand_b;
        wide = '0;
        ovf  = 1'b0;
        st_next = '0;
        // dividend doubled, divisor as is: the chain yields floor(2*num/den)
        st_next.num = fpa_pkg::NUM_W'({mag_a, fpa_pkg::FRAC_BITS'(0)}) << 1;
        st_next.den = fpa_pkg::DEN_W'(mag_b);
        st_next.side.product = in_word.operand_a * in_word.operand_b;
        unique case (fpa_pkg::op_t'(in_word.kind))
            fpa_pkg::OP_ADD: st_next.side.value = fpa_pkg::sat32(a + b, ovf);
            fpa_pkg::OP_SUB: st_next.side.value = fpa_pkg::sat32(a - b, ovf);
            fpa_pkg::OP_MUL: st_next.side.is_mul = 1'b1;
            fpa_pkg::OP_DIV:
            begin
                st_next.side.is_div = 1'b1;
                st_next.side.div0   = (in_word.operand_b == 32'sd0);
                st_next.side.neg    = in_word.operand_a[31] ^ in_word.operand_b[31];
            end
            fpa_pkg::OP_GT: st_next.side.compare_true = a > b;
            fpa_pkg::OP_LT: st_next.side.compare_true = a < b;
            fpa_pkg::OP_GE: st_next.side.compare_true = a >= b;
            fpa_pkg::OP_LE: st_next.side.compare_true = a <= b;
            fpa_pkg::OP_EQ: st_next.side.compare_true = a == b;
            fpa_pkg::OP_NE: st_next.side.compare_true = a != b;
            fpa_pkg::OP_MIN: st_next.side.value = (a < b) ? in_word.operand_a
                                                          : in_word.operand_b;
            fpa_pkg::OP_MAX: st_next.side.value = (a > b) ? in_word.operand_a
                                                          : in_word.operand_b;
            fpa_pkg::OP_INC: st_next.side.value = fpa_pkg::sat32(a + 66'sd1, ovf);
            fpa_pkg::OP_DEC: st_next.side.value = fpa_pkg::sat32(a - 66'sd1, ovf);
            fpa_pkg::OP_TO_INT: st_next.side.value = in_word.operand_a >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_FROM_INT:
            begin
                wide = a <<< fpa_pkg::FRAC_BITS;
                st_next.side.value = fpa_pkg::sat32(wide, ovf);
            end
            default: st_next.side.value = '0;
        endcase
        st_next.side.status = ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

endmodule

// ===== rtl/fpa_div_cell.sv =====
// one restoring-division cell: produces one quotient bit per cycle while en is high
module fpa_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                v_in,
    input  fpa_pkg::div_state_t st_in,
    output logic                v_reg,
    output fpa_pkg::div_state_t st_reg
);

    fpa_pkg::div_state_t st_next;
    logic [fpa_pkg::DEN_W:0] trial;

    always_comb
    begin
        st_next = st_in;
        trial = {st_in.rem, st_in.num[fpa_pkg::NUM_W-1]};
        st_next.num = st_in.num << 1;
        if (trial >= {1'b0, st_in.den})
        begin
            st_next.rem = fpa_pkg::DEN_W'(trial - {1'b0, st_in.den});
            st_next.quo = {st_in.quo[fpa_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            st_next.rem = fpa_pkg::DEN_W'(trial);
            st_next.quo = {st_in.quo[fpa_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

endmodule

// ===== rtl/fpa_back.sv =====
// back stage: rounds multiply and divide results, saturates them and flags division by zero
module fpa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                v_in,
    input  fpa_pkg::div_state_t st_in,
    output logic                v_reg,
    output fpa_pkg::out_word_t  out_reg
);

    fpa_pkg::out_word_t out_next;
    logic [63:0] pmag, pr;
    logic [fpa_pkg::QUO_W-1:0] q;
    logic signed [65:0] sv;
    logic ovf;

    always_comb
    begin
        out_next = '0;
        ovf = 1'b0;
        sv = '0;
        pmag = st_in.side.product[63] ? 64'(-st_in.side.product)
                                      : 64'(st_in.side.product);
        pr = (pmag + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        // the chain's quotient is floor(2*num/den), twice num/den; add one and halve to round
        q  = (st_in.quo + fpa_pkg::QUO_W'(1)) >> 1;
        out_next.value        = st_in.side.value;
        out_next.compare_true = st_in.side.compare_true;
        out_next.status       = st_in.side.status;
        if (st_in.side.is_mul)
        begin
            sv = st_in.side.product[63] ? -66'(pr) : 66'(pr);
            out_next.value  = fpa_pkg::sat32(sv, ovf);
            out_next.status = ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
        end
        else if (st_in.side.is_div)
        begin
            if (st_in.side.div0)
            begin
                out_next.value  = '0;
                out_next.status = fpa_pkg::ST_DIV0;
            end
            else
            begin
                sv = st_in.side.neg ? -66'(q) : 66'(q);
                out_next.value  = fpa_pkg::sat32(sv, ovf);
                out_next.status = ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

endmodule

// ===== dv/fixed_point_alu_q24_8_core_tb.sv =====
// testbench for the q24.8 fixed-point alu: random and corner operations checked in order
`timescale 1ns / 100ps

module fixed_point_alu_q24_8_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;

    class alu_scoreboard;
        fpa_pkg::out_word_t pending[$];
        int        errors;

        function automatic fpa_pkg::out_word_t compute(fpa_pkg::in_word_t w);
            fpa_pkg::out_word_t r;
            logic signed [65:0] a, b, v;
            logic signed [65:0] p;
            logic [65:0]      m, num, den, q;
            logic             neg;
            r = '0;
            a = w.operand_a;
            b = w.operand_b;
            v = 0;
            case (fpa_pkg::op_t'(w.kind))
                fpa_pkg::OP_ADD: v = a + b;
                fpa_pkg::OP_SUB: v = a - b;
                fpa_pkg::OP_MUL:
                begin
                    p   = a * b;
                    neg = p < 0;
                    m   = neg ? -p : p;
                    m   = (m + (66'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
                    v   = neg ? -$signed(m) : $signed(m);
                end
                fpa_pkg::OP_DIV:
                begin
                    if (b == 0)
                        r.status = fpa_pkg::ST_DIV0;
                    else
                    begin
                        num = (a < 0 ? -a : a) << fpa_pkg::FRAC_BITS;
                        den = b < 0 ? -b : b;
                        q   = (2 * num + den) / (2 * den);
                        v   = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
                    end
                end
                fpa_pkg::OP_GT: r.compare_true = a > b;
                fpa_pkg::OP_LT: r.compare_true = a < b;
                fpa_pkg::OP_GE: r.compare_true = a >= b;
                fpa_pkg::OP_LE: r.compare_true = a <= b;
                fpa_pkg::OP_EQ: r.compare_true = a == b;
                fpa_pkg::OP_NE: r.compare_true = a != b;
                fpa_pkg::OP_MIN: v = a < b ? a : b;
                fpa_pkg::OP_MAX: v = a > b ? a : b;
                fpa_pkg::OP_INC: v = a + 1;
                fpa_pkg::OP_DEC: v = a - 1;
                fpa_pkg::OP_TO_INT: v = a >>> fpa_pkg::FRAC_BITS;
                default: v = a * (66'sd1 <<< fpa_pkg::FRAC_BITS);
            endcase
            if (v > 66'sd2147483647)
            begin
                v        = 66'sd2147483647;
                r.status = fpa_pkg::ST_OVF;
            end
            else if (v < -66'sd2147483648)
            begin
                v        = -66'sd2147483648;
                r.status = fpa_pkg::ST_OVF;
            end
            r.value = v[31:0];
            return r;
        endfunction

        function void note_input(fpa_pkg::in_word_t w);
            pending.push_back(compute(w));
        endfunction

        function void check_result(fpa_pkg::out_word_t got);
            fpa_pkg::out_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.value !== exp_w.value)
            begin
                $display("%0t: value expected %0d actual %0d", $time, exp_w.value, got.value);
                errors++;
            end
            if (got.compare_true !== exp_w.compare_true)
            begin
                $display("%0t: compare_true expected %b actual %b", $time,
                         exp_w.compare_true, got.compare_true);
                errors++;
            end
            if (got.status !== exp_w.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_w.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    fpa_pkg::in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    fpa_pkg::out_word_t out_word;

    alu_scoreboard alu_sb = new();
    int  idle_cycles = 0;
    bit  stim_done = 0;
    bit  bursty = 0;

    fixed_point_alu_q24_8_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
        .out_word(out_word)
    );

    always #5 clk = ~clk;

    // accept on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                alu_sb.note_input(in_word);
            if (out_valid && !out_stall)
                alu_sb.check_result(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall, redrawn after each taken word
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = bursty ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            @(negedge clk);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 4095) - 2048;
            4: return ($urandom_range(0, 65535) - 32768) << 8;
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge; leaves in_valid high, the caller drops it
    task automatic send_word(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word  <= '{kind: kind, operand_a: a, operand_b: b};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        fpa_pkg::op_t op;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed corners, every operation
        for (int k = 0; k < 16; k++)
            send_word(k[3:0], 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(fpa_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000);
        send_word(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_word(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_word(fpa_pkg::OP_MUL, 32'h0000_0080, 32'hFFFF_FF01);
        send_word(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0);
        send_word(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_word(fpa_pkg::OP_DIV, 32'h0000_0001, 32'hFFFF_FE00);
        send_word(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'h0);
        send_word(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0);
        send_word(fpa_pkg::OP_TO_INT, 32'hFFFF_FFFF, 32'h0);
        in_valid <= 1'b0;
        // wait for the pipe to drain before going on
        wait (alu_sb.pending.size() == 0);
        @(negedge clk);
        for (int i = 0; i < 1500; i++)
        begin
            bursty = (i / 200) % 3 == 1;
            op     = fpa_pkg::op_t'($urandom_range(0, 15));
            send_word(op, pick_operand(), $urandom_range(0, 9) == 0 ? 32'h0 : pick_operand());
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            if (stim_done && alu_sb.pending.size() == 0)
            begin
                repeat (60) @(posedge clk);
                if (alu_sb.errors == 0 && alu_sb.pending.size() == 0)
                    $display("PASS");
                else
                    $display("FAIL");
                $finish;
            end
        end
    end
endmodule

// ===== sim.f =====
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div_cell.sv
rtl/fpa_back.sv
rtl/fixed_point_alu_q24_8_core.sv
dv/fixed_point_alu_q24_8_core_tb.sv
